### hw/rtl/sicq_pkg.sv
// ----------------------------------------------------------------------------
// sicq_pkg
// Types and codes for the syncpoint in-order completion queue.
// ----------------------------------------------------------------------------
`default_nettype none

package sicq_pkg;

  // command codes
  localparam logic [1:0] FUNC_IMM    = 2'd0;
  localparam logic [1:0] FUNC_DEFER  = 2'd1;
  localparam logic [1:0] FUNC_SIGNAL = 2'd2;

  // result kinds
  localparam logic [1:0] KIND_HANDLE   = 2'd0;
  localparam logic [1:0] KIND_INCR     = 2'd1;
  localparam logic [1:0] KIND_IDLE     = 2'd2;
  localparam logic [1:0] KIND_OVERFLOW = 2'd3;

  // results per command at most
  localparam int unsigned MaxResults = 16;
  localparam int unsigned NW         = $clog2(MaxResults + 1);

  typedef struct packed {
    logic [1:0]  func;
    logic [7:0]  sp_id;
    logic [31:0] done_handle;
  } item_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] new_handle;
    logic [7:0]  incr_syncpt;
    logic        last;
  } result_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_RDHEAD,
    ST_RETIRE
  } state_e;

endpackage

`default_nettype wire

### hw/rtl/syncpoint_in_order_completion_queue_core.sv
// ----------------------------------------------------------------------------
// syncpoint_in_order_completion_queue_core
// In-order queue of pending syncpoint increments with in-order retirement.
// ----------------------------------------------------------------------------
// A command is taken when start is high and busy is low; its results appear
// on result_o, each marked by result_valid_o for one cycle, the final one
// flagged by last. For a deferred increment, an overflow or an unused code
// the first result comes the cycle after the transfer; retired increments
// follow one per cycle. The receiver cannot stall, so every strobe must be
// taken. A deferred increment or an unused code keeps busy low. An immediate
// increment and a signal done retire completed entries from the head; a
// signal done first searches from the head and stops at the first entry whose
// handle matches, or when none of the queued entries match. The handle search
// reads one entry a cycle from the handle memory and compares it the cycle
// after; entries are retired from the head one per cycle through the
// syncpoint memory read port, at most 16. Entry handles and syncpoints live
// in memories; completion flags are flip-flops.
`default_nettype none

module syncpoint_in_order_completion_queue_core
  import sicq_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = 16
) (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    start,
  output logic         busy,
  input  wire item_t   item_i,
  output logic         result_valid_o,
  output result_t      result_o
);

  localparam int unsigned IW = $clog2(QUEUE_DEPTH);
  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);

  function automatic logic [IW-1:0] slot(input logic [IW-1:0] h, input logic [IW:0] off);
    logic [IW:0] sum;
    sum = {1'b0, h} + off;
    if (sum >= (IW+1)'(QUEUE_DEPTH)) begin
      sum = sum - (IW+1)'(QUEUE_DEPTH);
    end
    return sum[IW-1:0];
  endfunction

  logic [31:0] mem_handle [QUEUE_DEPTH];
  logic [7:0]  mem_sp     [QUEUE_DEPTH];

  state_e            state_q, state_d;
  logic [CW-1:0]     cnt_q, cnt_d;
  logic              cmp_vld_q, cmp_vld_d;
  logic [IW-1:0]     cmp_slot_q, cmp_slot_d;
  logic [NW-1:0]     n_q, n_d;
  logic [IW-1:0]     head_q, head_d;
  logic [CW-1:0]     count_q, count_d;
  logic [31:0]       next_handle_q, next_handle_d;
  logic [QUEUE_DEPTH-1:0] cmpl_q, cmpl_d;
  logic [31:0]       dh_q, dh_d;
  logic              out_vld_q, out_vld_d;
  result_t           out_q, out_d;

  logic [31:0]       rd_handle_q;
  logic [7:0]        rd_sp_q;
  logic [IW-1:0]     hrd_addr, srd_addr;
  logic              wr_en;
  logic [IW-1:0]     wr_addr;
  logic [31:0]       wr_handle;
  logic [7:0]        wr_sp;

  logic [IW-1:0]     tail, head_inc, search_slot;
  logic              full, retire_now, more;

  assign tail        = slot(head_q, (IW+1)'(count_q));
  assign head_inc    = slot(head_q, (IW+1)'(1));
  assign search_slot = slot(head_q, (IW+1)'(cnt_q));
  assign full        = (count_q == CW'(QUEUE_DEPTH));
  assign retire_now  = (n_q < NW'(MaxResults)) && (count_q != '0) && cmpl_q[head_q];
  assign more        = ((n_q + NW'(1)) < NW'(MaxResults)) && (count_q > CW'(1))
                       && cmpl_q[head_inc];

  always_comb begin
    state_d       = state_q;
    cnt_d         = cnt_q;
    cmp_vld_d     = 1'b0;
    cmp_slot_d    = cmp_slot_q;
    n_d           = n_q;
    head_d        = head_q;
    count_d       = count_q;
    next_handle_d = next_handle_q;
    cmpl_d        = cmpl_q;
    dh_d          = dh_q;
    out_vld_d     = 1'b0;
    out_d         = '0;
    hrd_addr      = search_slot;
    srd_addr      = head_q;
    wr_en         = 1'b0;
    wr_addr       = tail;
    wr_handle     = '0;
    wr_sp         = item_i.sp_id;

    case (state_q)
      ST_IDLE: begin
        if (start) begin
          n_d  = '0;
          dh_d = item_i.done_handle;
          case (item_i.func)
            FUNC_IMM: begin
              if (full) begin
                out_vld_d    = 1'b1;
                out_d.kind   = KIND_OVERFLOW;
                out_d.last   = ~cmpl_q[head_q];
                n_d          = NW'(1);
              end else begin
                wr_en          = 1'b1;
                cmpl_d[tail]   = 1'b1;
                count_d        = count_q + CW'(1);
              end
              state_d = ST_RDHEAD;
            end
            FUNC_DEFER: begin
              out_vld_d  = 1'b1;
              out_d.last = 1'b1;
              if (full) begin
                out_d.kind = KIND_OVERFLOW;
              end else begin
                wr_en            = 1'b1;
                wr_handle        = next_handle_q;
                cmpl_d[tail]     = 1'b0;
                count_d          = count_q + CW'(1);
                out_d.kind       = KIND_HANDLE;
                out_d.new_handle = next_handle_q;
                next_handle_d    = next_handle_q + 32'd1;
              end
            end
            FUNC_SIGNAL: begin
              cnt_d   = '0;
              state_d = ST_SEARCH;
            end
            default: begin
              out_vld_d  = 1'b1;
              out_d.kind = KIND_IDLE;
              out_d.last = 1'b1;
            end
          endcase
        end
      end

      ST_SEARCH: begin
        // read one entry a cycle, compare the one read the cycle before
        if (cnt_q < count_q) begin
          cnt_d      = cnt_q + CW'(1);
          cmp_vld_d  = 1'b1;
          cmp_slot_d = search_slot;
        end
        if (cmp_vld_q && (rd_handle_q == dh_q)) begin
          cmpl_d[cmp_slot_q] = 1'b1;
          cmp_vld_d          = 1'b0;
          state_d            = ST_RDHEAD;
        end else if (!cmp_vld_q && (cnt_q >= count_q)) begin
          state_d = ST_RDHEAD;
        end
      end

      ST_RDHEAD: begin
        srd_addr = head_q;
        state_d  = ST_RETIRE;
      end

      ST_RETIRE: begin
        if (retire_now) begin
          out_vld_d         = 1'b1;
          out_d.kind        = KIND_INCR;
          out_d.incr_syncpt = rd_sp_q;
          out_d.last        = ~more;
          cmpl_d[head_q]    = 1'b0;
          head_d            = head_inc;
          count_d           = count_q - CW'(1);
          n_d               = n_q + NW'(1);
          // prefetch the syncpoint of the next head
          srd_addr          = head_inc;
        end else begin
          if (n_q == '0) begin
            out_vld_d  = 1'b1;
            out_d.kind = KIND_IDLE;
            out_d.last = 1'b1;
          end
          state_d = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign busy           = (state_q != ST_IDLE);
  assign result_valid_o = out_vld_q;
  assign result_o       = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      cnt_q         <= '0;
      cmp_vld_q     <= 1'b0;
      n_q           <= '0;
      head_q        <= '0;
      count_q       <= '0;
      next_handle_q <= '0;
      cmpl_q        <= '0;
      out_vld_q     <= 1'b0;
    end else begin
      state_q       <= state_d;
      cnt_q         <= cnt_d;
      cmp_vld_q     <= cmp_vld_d;
      n_q           <= n_d;
      head_q        <= head_d;
      count_q       <= count_d;
      next_handle_q <= next_handle_d;
      cmpl_q        <= cmpl_d;
      out_vld_q     <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmp_slot_q <= cmp_slot_d;
    dh_q       <= dh_d;
    out_q      <= out_d;
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_handle[wr_addr] <= wr_handle;
      mem_sp[wr_addr]     <= wr_sp;
    end
    rd_handle_q <= mem_handle[hrd_addr];
    rd_sp_q     <= mem_sp[srd_addr];
  end

endmodule

`default_nettype wire
